[rtl/core/ibbl_pkg.sv]
package ibbl_pkg;
   localparam int Devices  = 16;
   localparam int Bindings = 64;
   localparam int SlotW    = 4;
   localparam int IdxW     = 6;
   localparam int CntW     = 7;
   localparam int CodeW    = 10;

   typedef enum logic [1:0] {
      CMD_CONNECT    = 2'd0,
      CMD_DISCONNECT = 2'd1,
      CMD_EVENT      = 2'd2,
      CMD_NONE       = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_NO_SLOT  = 3'd1,
      ST_NOT_ACQ  = 3'd2,
      ST_FULL     = 3'd3,
      ST_IGNORED  = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      MODE_CONNECTED   = 2'd0,
      MODE_CONFIGURING = 2'd1,
      MODE_READY       = 2'd2
   } mode_type;

   localparam logic CSR_THRESHOLD = 1'b0;
   localparam logic CSR_KEY_TYPE  = 1'b1;
endpackage

[rtl/core/ibbl_bind_ram.sv]
// Binding table: one row per slot and index, holds code and live flag.
module ibbl_bind_ram import ibbl_pkg::*; (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [SlotW+IdxW-1:0]   wr_addr,
   input  logic [CodeW:0]          wr_data,
   input  logic [SlotW+IdxW-1:0]   rd_addr,
   output logic [CodeW:0]          rd_data
);
   logic [CodeW:0] mem [Devices*Bindings];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

[rtl/core/input_button_binding_learner_core.sv]
// Each transaction passes through S_READ, S_DECIDE and S_FINISH; the result strobe is
// registered from S_FINISH. Key events that look up the binding table also pass through
// S_SCAN, which reads up to Bindings entries one at a time through the single read port
// of the table. Only one transaction is handled at a time; busy drops with the strobe,
// so the next one can be accepted in the strobe cycle.
// Reset (synchronous) frees all slots and restores register defaults; the receiver cannot stall.
module input_button_binding_learner_core import ibbl_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  logic [1:0]   req_cmd,
   input  logic [3:0]   req_device_slot,
   input  logic [4:0]   req_event_type,
   input  logic [9:0]   req_key_code,
   input  logic [1:0]   req_key_value,
   input  logic         csr_write_enable,
   input  logic [0:0]   csr_index,
   input  logic [7:0]   csr_write_data,
   output logic         rsp_strobe,
   output logic [2:0]   rsp_status,
   output logic [3:0]   rsp_slot,
   output logic [1:0]   rsp_mode,
   output logic [5:0]   rsp_binding_index,
   output logic         rsp_hit,
   output logic [4:0]   rsp_slots_in_use
);
   typedef enum logic [2:0] {
      S_IDLE, S_READ, S_DECIDE, S_SCAN, S_FINISH
   } state_type;

   localparam int RecW = 2 + 8 + CodeW + 1;

   state_type          state_ff;
   logic [7:0]         thr_ff;
   logic [4:0]         ktype_ff;
   logic [Devices-1:0] used_ff;
   logic [Devices-1:0] ever_ff;
   logic [4:0]         total_ff;

   // slot record memory: mode, count, last key, last valid
   logic [RecW-1:0]    rec_mem [Devices];
   logic [RecW-1:0]    rec_rd_ff;
   logic               rec_we;
   logic [RecW-1:0]    rec_wd;
   logic               rec_wr_ff;
   logic [RecW-1:0]    rec_new_ff;

   cmd_type            cmd_ff;
   logic [SlotW-1:0]   slot_ff;
   logic [4:0]         etype_ff;
   logic [CodeW-1:0]   code_ff;
   logic [1:0]         val_ff;

   logic [IdxW-1:0]    scan_ff;
   logic [IdxW-1:0]    didx_ff;
   logic [CntW-1:0]    lim_ff;
   logic               found_ff;
   logic [IdxW-1:0]    fidx_ff;
   logic               pend_ff;

   logic [CodeW:0]     brd;
   logic               bwe;
   logic [SlotW+IdxW-1:0] bwa, bra;
   logic [CodeW:0]     bwd;

   logic [1:0]         r_mode;
   logic [7:0]         r_cnt;
   logic [CodeW-1:0]   r_key;
   logic               r_kv;
   assign {r_mode, r_cnt, r_key, r_kv} = rec_rd_ff;

   ibbl_bind_ram u_bind (
      .clock(clock), .wr_en(bwe), .wr_addr(bwa), .wr_data(bwd),
      .rd_addr(bra), .rd_data(brd)
   );

   // lowest free slot
   logic [SlotW-1:0] free_slot;
   always_comb begin
      free_slot = '0;
      for (int k = Devices - 1; k >= 0; k--) begin
         if (!used_ff[k]) free_slot = SlotW'(k);
      end
   end

   logic valid_evt;
   assign valid_evt = used_ff[slot_ff] && etype_ff == ktype_ff && val_ff != 2'd0;

   // a slot never connected since reset has no record yet and reads as connected
   logic [1:0] cur_mode;
   assign cur_mode = ever_ff[slot_ff] ? r_mode : MODE_CONNECTED;

   // repeat counting in connected mode
   logic             same_key, enter_cfg, term;
   logic [7:0]       cnt_inc, cnt_new;
   logic [CodeW-1:0] key_new;
   logic [CntW-1:0]  lim_next;
   assign same_key  = r_kv && r_key == code_ff;
   assign cnt_inc   = (r_cnt == 8'hFF) ? r_cnt : r_cnt + 8'd1;
   assign cnt_new   = same_key ? cnt_inc : 8'd1;
   assign key_new   = same_key ? r_key : code_ff;
   assign enter_cfg = cnt_new >= thr_ff;
   assign term      = code_ff == r_key;
   assign lim_next  = (r_cnt > 8'(Bindings)) ? CntW'(Bindings) : r_cnt[CntW-1:0];

   // table scan compare
   logic hit_now, scan_last;
   assign hit_now   = brd[0] && brd[CodeW:1] == code_ff;
   assign scan_last = ({1'b0, didx_ff} + CntW'(1)) >= lim_ff;

   // decide the outcome once the slot record is available
   status_type       d_status;
   logic [SlotW-1:0] d_slot;
   logic [1:0]       d_mode;
   logic             d_rec_wr, d_scan, d_pend, d_use, d_free;
   logic [RecW-1:0]  d_rec;
   always_comb begin
      d_status = ST_IGNORED;
      d_slot   = slot_ff;
      d_mode   = cur_mode;
      d_rec_wr = 1'b0;
      d_rec    = rec_rd_ff;
      d_scan   = 1'b0;
      d_pend   = 1'b0;
      d_use    = 1'b0;
      d_free   = 1'b0;
      case (cmd_ff)
         CMD_CONNECT: begin
            d_mode = MODE_CONNECTED;
            if (total_ff < 5'(Devices)) begin
               d_status = ST_OK;
               d_use    = 1'b1;
               d_rec_wr = 1'b1;
               d_rec    = '0;
            end else begin
               d_status = ST_NO_SLOT;
               d_slot   = '0;
            end
         end
         CMD_DISCONNECT: begin
            if (used_ff[slot_ff]) begin
               d_status = ST_OK;
               d_free   = 1'b1;
            end else begin
               d_status = ST_NOT_ACQ;
            end
         end
         CMD_EVENT: begin
            if (valid_evt) begin
               d_status = ST_OK;
               case (r_mode)
                  MODE_CONNECTED: begin
                     d_rec_wr = 1'b1;
                     if (enter_cfg) begin
                        d_rec  = {MODE_CONFIGURING, 8'd0, key_new, 1'b1};
                        d_mode = MODE_CONFIGURING;
                     end else begin
                        d_rec  = {MODE_CONNECTED, cnt_new, key_new, 1'b1};
                        d_mode = MODE_CONNECTED;
                     end
                  end
                  MODE_CONFIGURING: begin
                     // ignore the terminal key before any binding exists
                     if (!(term && r_cnt == 8'd0)) begin
                        if (r_cnt >= 8'(Bindings)) begin
                           d_status = ST_FULL;
                           if (term) begin
                              d_rec_wr = 1'b1;
                              d_rec    = {MODE_READY, r_cnt, r_key, r_kv};
                              d_mode   = MODE_READY;
                           end
                        end else begin
                           d_pend = 1'b1;
                           d_scan = lim_next != '0;
                           d_mode = term ? MODE_READY : MODE_CONFIGURING;
                        end
                     end
                  end
                  MODE_READY: d_scan = lim_next != '0;
                  default: ;
               endcase
            end
         end
         default: d_slot = '0;
      endcase
   end

   // memory writes happen at the end of the transaction
   always_comb begin
      rec_we = 1'b0;
      rec_wd = rec_new_ff;
      if (state_ff == S_FINISH) begin
         if (pend_ff) begin
            rec_we = 1'b1;
            rec_wd = {term ? MODE_READY : MODE_CONFIGURING, r_cnt + 8'd1, r_key, r_kv};
         end else if (rec_wr_ff) begin
            rec_we = 1'b1;
         end
      end
   end

   assign bwe  = state_ff == S_FINISH && pend_ff;
   assign bwa  = {slot_ff, r_cnt[IdxW-1:0]};
   assign bwd  = {code_ff, !found_ff};
   assign bra  = {slot_ff, scan_ff};
   assign busy = state_ff != S_IDLE;

   // record memory read and write
   always_ff @(posedge clock) begin
      if (rec_we) rec_mem[slot_ff] <= rec_wd;
      rec_rd_ff <= rec_mem[slot_ff];
   end

   // main sequencer
   always_ff @(posedge clock) begin
      rsp_strobe <= !reset && state_ff == S_FINISH;
      if (reset) begin
         state_ff <= S_IDLE;
         thr_ff   <= 8'd10;
         ktype_ff <= 5'd1;
         used_ff  <= '0;
         ever_ff  <= '0;
         total_ff <= '0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_THRESHOLD: thr_ff <= csr_write_data;
               CSR_KEY_TYPE:  ktype_ff <= csr_write_data[4:0];
               default: ;
            endcase
         end
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  cmd_ff   <= cmd_type'(req_cmd);
                  etype_ff <= req_event_type;
                  code_ff  <= req_key_code;
                  val_ff   <= req_key_value;
                  slot_ff  <= (req_cmd == CMD_CONNECT) ? free_slot : req_device_slot;
                  scan_ff  <= '0;
                  state_ff <= S_READ;
               end
            end
            S_READ: state_ff <= S_DECIDE;
            S_DECIDE: begin
               rsp_status <= d_status;
               rsp_slot   <= d_slot;
               rsp_mode   <= d_mode;
               rec_wr_ff  <= d_rec_wr;
               rec_new_ff <= d_rec;
               pend_ff    <= d_pend;
               found_ff   <= 1'b0;
               fidx_ff    <= '0;
               lim_ff     <= lim_next;
               didx_ff    <= '0;
               scan_ff    <= IdxW'(1);
               state_ff   <= d_scan ? S_SCAN : S_FINISH;
               if (d_use) begin
                  used_ff[slot_ff] <= 1'b1;
                  ever_ff[slot_ff] <= 1'b1;
                  total_ff         <= total_ff + 5'd1;
               end else if (d_free) begin
                  used_ff[slot_ff] <= 1'b0;
                  total_ff         <= total_ff - 5'd1;
               end
            end
            S_SCAN: begin
               // one table entry per cycle; stop at the first live match
               if (hit_now) begin
                  found_ff <= 1'b1;
                  fidx_ff  <= didx_ff;
                  state_ff <= S_FINISH;
               end else if (scan_last) begin
                  state_ff <= S_FINISH;
               end else begin
                  didx_ff <= didx_ff + IdxW'(1);
                  scan_ff <= scan_ff + IdxW'(1);
               end
            end
            S_FINISH: begin
               state_ff          <= S_IDLE;
               rsp_slots_in_use  <= total_ff;
               rsp_hit           <= pend_ff || found_ff;
               rsp_binding_index <= found_ff ? fidx_ff :
                                    (pend_ff ? r_cnt[IdxW-1:0] : '0);
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

[rtl/core/ibbl_checker.sv]
module ibbl_checker import ibbl_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_strobe,
   input logic [2:0] rsp_status,
   input logic       rsp_hit,
   input logic [5:0] rsp_binding_index,
   input logic [4:0] rsp_slots_in_use
);
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("busy not raised");
   a_strobe_one: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("double strobe");
   a_hit_index: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_hit |-> rsp_binding_index == '0) else $error("stray index");
   a_in_use: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_slots_in_use <= 5'(Devices)) else $error("count overflow");
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_status <= ST_IGNORED) else $error("bad status");
endmodule

bind input_button_binding_learner_core ibbl_checker u_chk (.*);

[dv/binding_checker.sv]
`timescale 1ns / 100ps

module binding_checker import ibbl_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic         busy,
   input  logic [1:0]   req_cmd,
   input  logic [3:0]   req_device_slot,
   input  logic [4:0]   req_event_type,
   input  logic [9:0]   req_key_code,
   input  logic [1:0]   req_key_value,
   input  logic         csr_write_enable,
   input  logic [0:0]   csr_index,
   input  logic [7:0]   csr_write_data,
   input  logic         rsp_strobe,
   input  logic [2:0]   rsp_status,
   input  logic [3:0]   rsp_slot,
   input  logic [1:0]   rsp_mode,
   input  logic [5:0]   rsp_binding_index,
   input  logic         rsp_hit,
   input  logic [4:0]   rsp_slots_in_use,
   output int           error_count,
   output int           pending_count
);

   typedef struct packed {
      status_type status;
      logic [3:0] slot;
      mode_type   mode;
      logic [5:0] index;
      logic       hit;
      logic [4:0] in_use;
   } answer_type;

   // shadow of the block's state
   logic [7:0]  threshold;
   logic [4:0]  key_type;
   logic        used [Devices];
   int          used_total;
   mode_type    mode [Devices];
   int          count [Devices];
   logic [9:0]  last_code [Devices];
   logic        last_valid [Devices];
   logic [9:0]  code_tab [Devices][Bindings];
   logic        live_tab [Devices][Bindings];

   answer_type answers_due[$];

   assign pending_count = answers_due.size();

   function automatic int lookup_code(int s, logic [9:0] code);
      int n;
      n = (count[s] > Bindings) ? Bindings : count[s];
      for (int i = 0; i < n; i++)
         if (live_tab[s][i] && code_tab[s][i] == code) return i;
      return -1;
   endfunction

   function automatic void wipe_slot(int s);
      mode[s] = MODE_CONNECTED;
      count[s] = 0;
      last_code[s] = '0;
      last_valid[s] = 1'b0;
      for (int i = 0; i < Bindings; i++) begin
         code_tab[s][i] = '0;
         live_tab[s][i] = 1'b0;
      end
   endfunction

   // compute the answer of one transaction and advance the shadow state
   function automatic answer_type learn_step(logic [1:0] c, logic [3:0] sl, logic [4:0] et,
                                             logic [9:0] code, logic [1:0] val);
      answer_type a;
      int s, prev, n;
      logic in_range, term;
      a = '0;
      a.status = ST_IGNORED;
      s = int'(sl);
      in_range = 1'b1;
      if (c == CMD_CONNECT) begin
         a.status = ST_NO_SLOT;
         in_range = 1'b0;
         for (int k = 0; k < Devices; k++)
            if (!used[k]) begin
               used[k] = 1'b1;
               used_total++;
               wipe_slot(k);
               a.status = ST_OK;
               s = k;
               a.slot = 4'(k);
               in_range = 1'b1;
               break;
            end
      end else if (c == CMD_DISCONNECT) begin
         a.slot = sl;
         a.status = ST_NOT_ACQ;
         if (used[s]) begin
            used[s] = 1'b0;
            used_total--;
            a.status = ST_OK;
         end
      end else if (c == CMD_EVENT) begin
         a.slot = sl;
         if (used[s] && et == key_type && val != 2'd0) begin
            a.status = ST_OK;
            if (mode[s] == MODE_CONNECTED) begin
               if (last_valid[s] && last_code[s] == code) begin
                  if (count[s] < 255) count[s]++;
               end else begin
                  last_code[s] = code;
                  last_valid[s] = 1'b1;
                  count[s] = 1;
               end
               if (count[s] >= int'(threshold)) begin
                  mode[s] = MODE_CONFIGURING;
                  count[s] = 0;
               end
            end else if (mode[s] == MODE_CONFIGURING) begin
               term = (code == last_code[s]);
               if (!(term && count[s] == 0)) begin
                  if (count[s] >= Bindings) begin
                     a.status = ST_FULL;
                  end else begin
                     prev = lookup_code(s, code);
                     n = count[s];
                     code_tab[s][n] = code;
                     live_tab[s][n] = (prev < 0);
                     a.index = (prev < 0) ? 6'(n) : 6'(prev);
                     a.hit = 1'b1;
                     count[s] = n + 1;
                  end
                  if (term) mode[s] = MODE_READY;
               end
            end else begin
               prev = lookup_code(s, code);
               if (prev >= 0) begin
                  a.index = 6'(prev);
                  a.hit = 1'b1;
               end
            end
         end
      end
      a.mode = in_range ? mode[s] : MODE_CONNECTED;
      a.in_use = 5'(used_total);
      return a;
   endfunction

   // watch both channels at the rising edge
   always @(posedge clock) begin
      answer_type got, want;
      if (reset) begin
         threshold = 8'd10;
         key_type = 5'd1;
         used_total = 0;
         for (int s = 0; s < Devices; s++) begin
            used[s] = 1'b0;
            wipe_slot(s);
         end
         answers_due.delete();
         error_count = 0;
      end else begin
         if (rsp_strobe) begin
            got = '{status_type'(rsp_status), rsp_slot, mode_type'(rsp_mode),
                    rsp_binding_index, rsp_hit, rsp_slots_in_use};
            if (answers_due.size() == 0) begin
               $display("%0t: unexpected result, actual %p", $time, got);
               error_count++;
            end else begin
               want = answers_due.pop_front();
               if (got.status !== want.status || got.slot !== want.slot ||
                   got.mode !== want.mode || got.index !== want.index ||
                   got.hit !== want.hit || got.in_use !== want.in_use) begin
                  $display("%0t: mismatch, expected %p, actual %p", $time, want, got);
                  error_count++;
               end
            end
         end
         if (csr_write_enable) begin
            if (csr_index == CSR_THRESHOLD) threshold = csr_write_data;
            else key_type = csr_write_data[4:0];
         end
         if (start && !busy)
            answers_due.push_back(learn_step(req_cmd, req_device_slot, req_event_type,
                                             req_key_code, req_key_value));
      end
   end

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps

module testbench;
   import ibbl_pkg::*;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   logic [1:0]   req_cmd = '0;
   logic [3:0]   req_device_slot = '0;
   logic [4:0]   req_event_type = '0;
   logic [9:0]   req_key_code = '0;
   logic [1:0]   req_key_value = '0;
   logic         csr_write_enable = 1'b0;
   logic [0:0]   csr_index = '0;
   logic [7:0]   csr_write_data = '0;
   logic         rsp_strobe;
   logic [2:0]   rsp_status;
   logic [3:0]   rsp_slot;
   logic [1:0]   rsp_mode;
   logic [5:0]   rsp_binding_index;
   logic         rsp_hit;
   logic [4:0]   rsp_slots_in_use;
   int           error_count;
   int           pending_count;
   logic [4:0]   key_type_now = 5'd1;
   logic [7:0]   threshold_now = 8'd10;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   input_button_binding_learner_core u_dut (.*);
   binding_checker u_checker (.*);

   // hold one transaction until it is accepted, with an optional idle burst first;
   // start stays high afterwards until the next transaction or an explicit drop
   task automatic send_item(logic [1:0] c, logic [3:0] s, logic [4:0] et,
                            logic [9:0] code, logic [1:0] val, bit gaps);
      if (gaps && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      start <= 1'b1;
      req_cmd <= c;
      req_device_slot <= s;
      req_event_type <= et;
      req_key_code <= code;
      req_key_value <= val;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic key_press(logic [3:0] s, logic [9:0] code, bit gaps);
      send_item(CMD_EVENT, s, key_type_now, code, 2'($urandom_range(1, 2)), gaps);
   endtask

   // wait until the block is drained, then write one register
   task automatic write_reg(logic [0:0] idx, logic [7:0] data);
      start <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (80) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_THRESHOLD) threshold_now = data;
      else key_type_now = data[4:0];
   endtask

   // drive one slot through learning: repeat, bind codes, terminate
   task automatic learn_sequence(logic [3:0] s, int nbind, bit gaps);
      logic [9:0] term, code;
      term = 10'($urandom);
      repeat ((threshold_now == 0) ? 1 : threshold_now) key_press(s, term, gaps);
      for (int i = 0; i < nbind; i++) begin
         code = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 7)) : 10'($urandom);
         if (code == term) code = code ^ 10'h200;
         key_press(s, code, gaps);
      end
      key_press(s, term, gaps);
   endtask

   // random well-formed traffic, with a share of noise
   task automatic random_traffic(int n, bit gaps);
      int r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 10) send_item(CMD_CONNECT, 4'($urandom), 5'($urandom), 10'($urandom),
                               2'($urandom), gaps);
         else if (r < 16) send_item(CMD_DISCONNECT, 4'($urandom), 5'($urandom),
                                    10'($urandom), 2'($urandom), gaps);
         else if (r < 22) send_item(2'($urandom), 4'($urandom), 5'($urandom),
                                    10'($urandom), 2'($urandom), gaps);
         else if (r < 40) learn_sequence(4'($urandom), $urandom_range(0, 6), gaps);
         else key_press(4'($urandom), 10'($urandom_range(0, 7)), gaps);
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: fill and overflow the slots, a good and a bad disconnect, unused command, rejected key events
      for (int i = 0; i < 17; i++) send_item(CMD_CONNECT, '0, '0, '0, '0, 0);
      send_item(CMD_DISCONNECT, 4'd15, 5'd31, 10'h3FF, 2'd3, 0);
      send_item(CMD_DISCONNECT, 4'd15, '0, '0, '0, 0);
      send_item(CMD_NONE, 4'd3, 5'd1, 10'h3FF, 2'd1, 0);
      send_item(CMD_EVENT, 4'd15, 5'd1, 10'd5, 2'd1, 0);
      send_item(CMD_EVENT, 4'd0, 5'd1, 10'd5, 2'd0, 0);
      send_item(CMD_EVENT, 4'd0, 5'd31, 10'd5, 2'd1, 0);

      // threshold of one, early terminal key, full table, lookups in ready mode
      write_reg(CSR_THRESHOLD, 8'd1);
      key_press(4'd1, 10'h3FF, 0);
      key_press(4'd1, 10'h3FF, 0);
      for (int i = 0; i < 66; i++) key_press(4'd1, 10'(i % 70), 0);
      key_press(4'd1, 10'h3FF, 0);
      key_press(4'd1, 10'd0, 0);
      key_press(4'd1, 10'd500, 0);
      learn_sequence(4'd2, 4, 0);

      // pause until drained, then random phases under several settings
      write_reg(CSR_THRESHOLD, 8'd0);
      write_reg(CSR_KEY_TYPE, 8'd31);
      random_traffic(60, 1);
      write_reg(CSR_THRESHOLD, 8'd255);
      write_reg(CSR_KEY_TYPE, 8'd0);
      learn_sequence(4'd3, 2, 1);
      write_reg(CSR_THRESHOLD, 8'd3);
      write_reg(CSR_KEY_TYPE, 8'($urandom_range(0, 31)));
      random_traffic(60, 1);
      write_reg(CSR_THRESHOLD, 8'd2);
      random_traffic(40, 0);

      start <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (80) @(negedge clock);
      if (error_count == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

   initial begin
      #60ms;
      $display("TEST FAILED");
      $finish;
   end

endmodule
